/* src/stup_pkg.sv */
// ----------------------------------------------------------------------------
// stup_pkg
// Shared types and constants of the unsigned integer string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stup_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_LEN     = 4096;
   localparam int POS_WIDTH   = 12;
   localparam int OFFSET_MAX  = (MAX_LEN - 1 < 4095) ? (MAX_LEN - 1) : 4095;
   localparam int PROD_WIDTH  = VALUE_WIDTH + 7;

   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] BASE_OCT   = 6'd8;
   localparam logic [RADIX_WIDTH-1:0] BASE_DEC   = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] BASE_HEX   = 6'd16;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_NUM   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_BAD_BASE = 2'd3;

   // register index on the configuration port
   localparam logic REG_RADIX = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_SIGNED,
      PH_ZERO,
      PH_ZEROX,
      PH_DIGITS
   } phase_type;

   // one classified character as it travels from front to back
   typedef struct packed {
      logic                   first;
      logic [RADIX_WIDTH-1:0] radix;
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   is_space;
      logic                   is_minus;
      logic                   is_plus;
      logic                   is_zero;
      logic                   is_x;
   } class_type;

endpackage

`default_nettype wire

/* src/stup_front.sv */
// ----------------------------------------------------------------------------
// stup_front
// Accepts characters, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stup_front
   import stup_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [7:0]             req_character,
   input  wire logic                   req_first,
   input  wire logic [RADIX_WIDTH-1:0] radix,
   output logic                        q_valid,
   output class_type                   q_data,
   input  wire logic                   q_take
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   class_type         slot_ff [DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [AW-1:0]     rptr_ff, rptr_in;
   logic [AW:0]       count_ff, count_in;
   class_type         cls;
   logic              accept;

   always_comb begin
      cls          = '0;
      cls.first    = req_first;
      cls.radix    = radix;
      cls.is_space = (req_character inside {8'd32, [8'd9:8'd13]});
      cls.is_minus = (req_character == "-");
      cls.is_plus  = (req_character == "+");
      cls.is_zero  = (req_character == "0");
      cls.is_x     = (req_character == "x") || (req_character == "X");
      if (req_character inside {["0":"9"]}) begin
         cls.digit = DIGIT_WIDTH'(req_character - 8'("0"));
      end else if (req_character inside {["a":"z"]}) begin
         cls.digit = DIGIT_WIDTH'(req_character - 8'("a") + 8'd10);
      end else if (req_character inside {["A":"Z"]}) begin
         cls.digit = DIGIT_WIDTH'(req_character - 8'("A") + 8'd10);
      end else begin
         cls.digit = DIGIT_NONE;
      end
   end

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign accept  = push && !full;
   assign q_valid = (count_ff != '0);
   assign q_data  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + AW'(accept);
      rptr_in  = rptr_ff + AW'(q_take);
      count_in = count_ff + (AW+1)'(accept) - (AW+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

/* src/stup_back.sv */
// ----------------------------------------------------------------------------
// stup_back
// Runs the parse on classified characters and queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module stup_back
   import stup_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire class_type   q_data,
   output logic             q_take,
   output logic             empty,
   input  wire logic        pop,
   output logic [63:0]      rsp_value,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_end_offset
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   phase_type               phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [RADIX_WIDTH-1:0]  base_ff, base_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   logic                    ovf_ff, ovf_in;

   logic                    emit;
   logic [VALUE_WIDTH-1:0]  res_value;
   logic [1:0]              res_status;
   logic [POS_WIDTH-1:0]    res_offset;
   logic                    do_start, do_digit, count_pos;
   logic [PROD_WIDTH-1:0]   sum;

   logic [63:0]             val_ff  [DEPTH];
   logic [1:0]              stat_ff [DEPTH];
   logic [11:0]             off_ff  [DEPTH];
   logic [AW-1:0]           wptr_ff, rptr_ff;
   logic [AW:0]             count_ff;
   logic                    out_full, out_pop;

   assign out_full = (count_ff == (AW+1)'(DEPTH));
   assign q_take   = q_valid && !out_full;

   always_comb begin
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      ovf_in     = ovf_ff;
      emit       = 1'b0;
      res_value  = '0;
      res_status = ST_OK;
      res_offset = '0;
      do_start   = 1'b0;
      do_digit   = 1'b0;
      count_pos  = 1'b0;
      sum        = '0;
      if (q_take) begin
         count_pos = 1'b1;
         if (q_data.first) begin
            neg_in  = 1'b0;
            acc_in  = '0;
            ovf_in  = 1'b0;
            pos_in  = '0;
            base_in = q_data.radix;
            phase_in = PH_LEAD;
            if (q_data.radix == 6'd1 || q_data.radix > RADIX_MAX) begin
               emit       = 1'b1;
               res_status = ST_BAD_BASE;
               phase_in   = PH_IDLE;
               count_pos  = 1'b0;
            end
         end
         if (count_pos) begin
            case (phase_in)
               PH_LEAD: begin
                  if (q_data.is_space) begin
                     // skip leading whitespace
                  end else if (q_data.is_minus) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGNED;
                  end else if (q_data.is_plus) begin
                     phase_in = PH_SIGNED;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               PH_SIGNED: do_start = 1'b1;
               PH_ZERO: begin
                  if (q_data.is_x) begin
                     base_in  = BASE_HEX;
                     phase_in = PH_ZEROX;
                  end else begin
                     if (base_in == RADIX_AUTO) begin
                        base_in = BASE_OCT;
                     end
                     do_digit = 1'b1;
                  end
               end
               PH_ZEROX: begin
                  if (q_data.digit < 6'(BASE_HEX)) begin
                     acc_in   = VALUE_WIDTH'(q_data.digit);
                     phase_in = PH_DIGITS;
                  end else begin
                     // number is the lone zero; end points at the x
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                     if (pos_in >= POS_WIDTH'(OFFSET_MAX) || pos_in == '0) begin
                        res_offset = pos_in;
                     end else begin
                        res_offset = pos_in - 1'b1;
                     end
                  end
               end
               PH_DIGITS: do_digit = 1'b1;
               default: count_pos = 1'b0;
            endcase

            if (do_start) begin
               if (base_in == RADIX_AUTO && !q_data.is_zero) begin
                  base_in = BASE_DEC;
               end
               if (q_data.is_zero && (base_in == RADIX_AUTO || base_in == BASE_HEX)) begin
                  acc_in   = '0;
                  phase_in = PH_ZERO;
               end else if (q_data.digit < base_in) begin
                  acc_in   = VALUE_WIDTH'(q_data.digit);
                  phase_in = PH_DIGITS;
               end else begin
                  emit       = 1'b1;
                  res_status = ST_NO_NUM;
                  phase_in   = PH_IDLE;
               end
            end

            if (do_digit) begin
               if (q_data.digit < base_in) begin
                  phase_in = PH_DIGITS;
                  if (!ovf_in) begin
                     sum = PROD_WIDTH'(acc_in) * PROD_WIDTH'(base_in)
                         + PROD_WIDTH'(q_data.digit);
                     if (sum[PROD_WIDTH-1:VALUE_WIDTH] != '0) begin
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = sum[VALUE_WIDTH-1:0];
                     end
                  end
               end else begin
                  emit       = 1'b1;
                  phase_in   = PH_IDLE;
                  res_offset = pos_in;
                  if (ovf_in) begin
                     res_value  = '1;
                     res_status = ST_OVERFLOW;
                  end else begin
                     res_value = neg_in ? (VALUE_WIDTH'(0) - acc_in) : acc_in;
                  end
               end
            end

            if (count_pos && pos_in < POS_WIDTH'(OFFSET_MAX)) begin
               pos_in = pos_in + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         ovf_ff   <= ovf_in;
      end
   end

   // result queue
   assign empty          = (count_ff == '0);
   assign out_pop        = pop && !empty;
   assign rsp_value      = val_ff[rptr_ff];
   assign rsp_status     = stat_ff[rptr_ff];
   assign rsp_end_offset = off_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_ff + AW'(emit);
         rptr_ff  <= rptr_ff + AW'(out_pop);
         count_ff <= count_ff + (AW+1)'(emit) - (AW+1)'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         val_ff[wptr_ff]  <= 64'(res_value);
         stat_ff[wptr_ff] <= res_status;
         off_ff[wptr_ff]  <= 12'(res_offset);
      end
   end

endmodule

`default_nettype wire

/* src/string_to_unsigned_parser_core.sv */
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core
// Streaming string to unsigned integer parser, one character per word.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   input     push / full           req_character, req_first
//   result    empty / pop           rsp_value, rsp_status, rsp_end_offset
//   config    psel/penable/pwrite   paddr, pwdata, prdata (radix at 0)
//
// One character per cycle while the result queue has room; the back end does
// one 64x6 multiply-add per cycle, and a character's result is queued in the
// cycle after it is taken. Reset is synchronous and clears both queues and the
// parse state. A stalled result side fills the 2-entry result queue and then
// the 4-entry character queue before full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_unsigned_parser_core
   import stup_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_character,
   input  wire logic        req_first,
   output logic             empty,
   input  wire logic        pop,
   output logic [63:0]      rsp_value,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_end_offset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [RADIX_WIDTH-1:0] radix_ff;
   logic                   q_valid, q_take;
   class_type              q_data;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == REG_RADIX) begin
         radix_ff <= pwdata[RADIX_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_RADIX) begin
         prdata = 32'(radix_ff);
      end
   end

   stup_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_character (req_character),
      .req_first     (req_first),
      .radix         (radix_ff),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_take        (q_take)
   );

   stup_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_take         (q_take),
      .empty          (empty),
      .pop            (pop),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_end_offset (rsp_end_offset)
   );

endmodule

`default_nettype wire

/* tb/parse_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parse_result_checker
// Watches the character, result and register channels of the parser, predicts
// each parse result from the accepted characters and compares field by field.
// ----------------------------------------------------------------------------

module parse_result_checker
   import stup_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic        full,
   input  wire logic [7:0]  req_character,
   input  wire logic        req_first,
   input  wire logic        empty,
   input  wire logic        pop,
   input  wire logic [63:0] rsp_value,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [11:0] rsp_end_offset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic        pready,
   output int               fails,
   output int               pending,
   output int               results_seen,
   output int               overflows,
   output int               no_numbers,
   output int               bad_bases
);

   localparam logic [63:0] VMASK = (VALUE_WIDTH >= 64) ? {64{1'b1}} :
                                   ((64'd1 << VALUE_WIDTH) - 64'd1);

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
      logic [11:0] end_offset;
   } parse_result_type;

   parse_result_type expected_results[$];

   // predicted parse state
   phase_type   phase;
   logic        neg;
   logic        ovf;
   logic [5:0]  work_base;
   logic [5:0]  radix_q;
   logic [63:0] acc;
   logic [11:0] pos;

   function automatic logic [5:0] char_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 6'(c - "0");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd10);
      if (c >= "A" && c <= "Z") return 6'(c - "A" + 8'd10);
      return DIGIT_NONE;
   endfunction

   function automatic logic char_is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fails++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic post_result(input logic [63:0] v, input logic [1:0] s,
                              input logic [11:0] off);
      parse_result_type r;
      r.value      = v;
      r.status     = s;
      r.end_offset = off;
      expected_results.push_back(r);
      phase = PH_IDLE;
   endtask

   task automatic add_digit(input logic [5:0] d);
      logic [63:0] b;
      b = (work_base != 6'd0) ? 64'(work_base) : 64'd1;
      if (ovf) return;
      if (acc > VMASK / b) begin
         ovf = 1'b1;
         return;
      end
      acc = acc * b;
      if (VMASK - acc < 64'(d)) begin
         ovf = 1'b1;
         return;
      end
      acc = acc + 64'(d);
   endtask

   task automatic take_digit(input logic [7:0] c);
      logic [5:0] d;
      d = char_digit(c);
      if (d < work_base) begin
         add_digit(d);
         phase = PH_DIGITS;
      end else if (ovf) begin
         post_result(VMASK, ST_OVERFLOW, pos);
      end else begin
         post_result((neg ? (64'd0 - acc) : acc) & VMASK, ST_OK, pos);
      end
   endtask

   task automatic begin_number(input logic [7:0] c);
      logic [5:0] d;
      if (work_base == RADIX_AUTO && c != "0") work_base = BASE_DEC;
      if (c == "0" && (work_base == RADIX_AUTO || work_base == BASE_HEX)) begin
         acc   = 64'd0;
         phase = PH_ZERO;
      end else begin
         d = char_digit(c);
         if (d < work_base) begin
            acc   = 64'(d);
            phase = PH_DIGITS;
         end else begin
            post_result(64'd0, ST_NO_NUM, 12'd0);
         end
      end
   endtask

   task automatic predict_parse(input logic [7:0] c, input logic f);
      logic [5:0]  d;
      logic [11:0] off;
      if (f) begin
         neg       = 1'b0;
         acc       = 64'd0;
         ovf       = 1'b0;
         pos       = 12'd0;
         work_base = radix_q;
         if (radix_q == 6'd1 || radix_q > RADIX_MAX) begin
            post_result(64'd0, ST_BAD_BASE, 12'd0);
            return;
         end
         phase = PH_LEAD;
      end
      case (phase)
         PH_LEAD: begin
            if (char_is_space(c)) begin
               // skip leading blanks
            end else if (c == "-") begin
               neg   = 1'b1;
               phase = PH_SIGNED;
            end else if (c == "+") begin
               phase = PH_SIGNED;
            end else begin
               begin_number(c);
            end
         end
         PH_SIGNED: begin_number(c);
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               work_base = BASE_HEX;
               phase     = PH_ZEROX;
            end else begin
               if (work_base == RADIX_AUTO) work_base = BASE_OCT;
               take_digit(c);
            end
         end
         PH_ZEROX: begin
            d = char_digit(c);
            if (d < BASE_HEX) begin
               acc   = 64'(d);
               phase = PH_DIGITS;
            end else begin
               // the number is just the leading zero; end points at the x
               off = (pos >= OFFSET_MAX || pos == 12'd0) ? pos : pos - 12'd1;
               post_result(64'd0, ST_OK, off);
            end
         end
         PH_DIGITS: take_digit(c);
         default: return;
      endcase
      if (pos < OFFSET_MAX) pos++;
   endtask

   task automatic check_result();
      parse_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected", rsp_value, 64'd0);
         return;
      end
      want = expected_results.pop_front();
      results_seen++;
      if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
      if (rsp_status !== want.status)
         report_mismatch("status", 64'(rsp_status), 64'(want.status));
      if (rsp_end_offset !== want.end_offset)
         report_mismatch("end_offset", 64'(rsp_end_offset), 64'(want.end_offset));
      case (want.status)
         ST_OVERFLOW: overflows++;
         ST_NO_NUM:   no_numbers++;
         ST_BAD_BASE: bad_bases++;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         phase     = PH_IDLE;
         neg       = 1'b0;
         ovf       = 1'b0;
         work_base = RADIX_AUTO;
         radix_q   = RADIX_AUTO;
         acc       = 64'd0;
         pos       = 12'd0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == {REG_RADIX, 2'b00})
            radix_q = pwdata[5:0];
         if (pop && !empty) check_result();
         if (push && !full) predict_parse(req_character, req_first);
      end
      pending <= expected_results.size();
   end

endmodule

/* tb/string_to_unsigned_parser_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core_test
// Drives strings of characters into the parser under a range of radix
// settings, with bursty input, a stalling result side, and a side checker.
// ----------------------------------------------------------------------------

module string_to_unsigned_parser_core_test;
   import stup_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 24;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        push          = 1'b0;
   logic [7:0]  req_character = 8'd0;
   logic        req_first     = 1'b0;
   logic        pop           = 1'b0;
   logic        psel          = 1'b0;
   logic        penable       = 1'b0;
   logic        pwrite        = 1'b0;
   logic [2:0]  paddr         = 3'd0;
   logic [31:0] pwdata        = 32'd0;

   wire logic        full;
   wire logic        empty;
   wire logic [63:0] rsp_value;
   wire logic [1:0]  rsp_status;
   wire logic [11:0] rsp_end_offset;
   wire logic [31:0] prdata;
   wire logic        pready;

   int fails, pending, results_seen, overflows, no_numbers, bad_bases;
   int cycles         = 0;
   int words_sent     = 0;
   int settings_done  = 0;
   int burst_left     = 0;
   int hold_left      = 0;
   int pop_mode       = 0;
   int mode_left      = 0;
   bit hold_start     = 1'b0;
   bit at_start       = 1'b0;
   logic [5:0] current_radix = RADIX_AUTO;
   int radix_plan [14] = '{0, 10, 16, 8, 2, 36, 1, 37, 63, 0, 16, 7, 35, 0};

   initial begin
      forever #5 clock = ~clock;
   end

   string_to_unsigned_parser_core uut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_character  (req_character),
      .req_first      (req_first),
      .empty          (empty),
      .pop            (pop),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_end_offset (rsp_end_offset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   parse_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_character  (req_character),
      .req_first      (req_first),
      .empty          (empty),
      .pop            (pop),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_end_offset (rsp_end_offset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .fails          (fails),
      .pending        (pending),
      .results_seen   (results_seen),
      .overflows      (overflows),
      .no_numbers     (no_numbers),
      .bad_bases      (bad_bases)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: the stall pattern is redrawn at random as each run ends, and
   // a long hold-off runs whenever one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = 300;
            pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               pop_mode  = $urandom_range(2, 0);
               mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            case (pop_mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(1, 0));
               default: pop <= ($urandom_range(3, 0) == 0);
            endcase
         end
      end
   end

   // offer one word and hold it until taken; keep push up inside a burst
   task automatic send_word(input logic [7:0] c, input logic f);
      push          <= 1'b1;
      req_character <= c;
      req_first     <= f;
      @(posedge clock);
      while (full) @(posedge clock);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         push <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(9, 0) == 0) ? 200 : $urandom_range(24, 0);
      end
   endtask

   task automatic string_word(input logic [7:0] c);
      send_word(c, at_start);
      at_start = 1'b0;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], i == 0);
   endtask

   // wait until every result is back and the block has gone quiet
   task automatic drain();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_radix(input logic [5:0] val);
      logic [31:0] data;
      data      = $urandom();
      data[5:0] = val;
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {REG_RADIX, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      current_radix = val;
      settings_done++;
   endtask

   function automatic logic [7:0] digit_char(input int v);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1, 0) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] blank_char();
      int pick;
      pick = $urandom_range(5, 0);
      return (pick == 5) ? " " : 8'(9 + pick);
   endfunction

   // one string: blanks, sign, prefix, base digits, ending; or 1-4 random words
   task automatic send_number();
      int base;
      int ndig;
      int pick;
      if ($urandom_range(9, 0) == 0) begin
         repeat ($urandom_range(4, 1))
            send_word(8'($urandom()), $urandom_range(3, 0) == 0);
         return;
      end
      at_start = 1'b1;
      pick = $urandom_range(5, 0);
      repeat ((pick > 2) ? pick - 2 : 0) string_word(blank_char());
      pick = $urandom_range(3, 0);
      if (pick == 0) string_word("-");
      else if (pick == 1) string_word("+");
      base = int'(current_radix);
      if (current_radix == RADIX_AUTO) begin
         pick = $urandom_range(2, 0);
         if (pick == 0) begin
            base = 16;
            string_word("0");
            string_word($urandom_range(1, 0) ? "x" : "X");
         end else if (pick == 1) begin
            base = 8;
            string_word("0");
         end else begin
            base = 10;
         end
      end else if (current_radix == BASE_HEX && $urandom_range(1, 0)) begin
         string_word("0");
         string_word($urandom_range(1, 0) ? "x" : "X");
      end else if (current_radix == 6'd1 || current_radix > RADIX_MAX) begin
         base = 10;
      end
      pick = $urandom_range(15, 0);
      ndig = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(70, 14) : $urandom_range(8, 1);
      repeat (ndig) string_word(digit_char($urandom_range(base - 1, 0)));
      case ($urandom_range(5, 0))
         0: ;  // no ending: the next string restarts the parse
         1: string_word(" ");
         2: string_word(",");
         3: string_word(8'($urandom()));
         4: string_word(8'h00);
         default: string_word(8'hFF);
      endcase
   endtask

   initial begin
      int n;
      radix_plan[13] = $urandom_range(36, 2);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, at the reset radix (automatic)
      send_word(8'hFF, 1'b0);
      send_text(" \t-0xZ");
      send_text("017!");
      send_text("+ 7");
      send_text("12");
      send_text("0X1f");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      send_text("9");
      send_word(8'h80, 1'b0);
      drain();

      foreach (radix_plan[p]) begin
         write_radix(6'(radix_plan[p]));
         if (p == 1) hold_start = 1'b1;
         n = (radix_plan[p] == 1 || radix_plan[p] > 36) ? 8 : 20;
         repeat (n) send_number();
         drain();
      end

      $display("Sent %0d words under %0d radix settings; %0d results checked.",
               words_sent, settings_done, results_seen);
      $display("Among them %0d overflows, %0d with no number, %0d with a bad base.",
               overflows, no_numbers, bad_bases);
      if (fails == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
